/* sv/amp_pkg.sv */
// Shared types, codes and widths of the monitoring-policy builder.
package amp_pkg;

  localparam int COST_BINS_DEF = 16;
  localparam int TIME_BINS_DEF = 16;

  localparam int IDX_W  = 6;
  localparam int PROB_W = 17;
  localparam int CFG_W  = 16;
  localparam int VAL_W  = 48;
  localparam int WAIT_W = 22;
  localparam int TERM_W = 50;
  localparam int ACC_W  = 58;
  localparam int UTIL_W = 40;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] REG_WEIGHT_COST = 2'd0;
  localparam logic [1:0] REG_WEIGHT_TIME = 2'd1;
  localparam logic [1:0] REG_COST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_TIME_WIDTH  = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] weight_cost;
    logic [CFG_W-1:0] weight_time;
    logic [CFG_W-1:0] cost_width;
    logic [CFG_W-1:0] time_width;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    compute_done;
    logic                    stop_flag;
    logic [WAIT_W-1:0]       wait_time;
    logic signed [VAL_W-1:0] policy_value;
  } res_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_READ, SQ_PREP, SQ_INIT_U, SQ_INIT_W,
    SQ_UTIL, SQ_FETCH, SQ_SCALE, SQ_DECIDE, SQ_WRITE, SQ_DONE
  } seq_e;

  typedef enum logic [2:0] {
    SC_IDLE, SC_LO, SC_HI, SC_SUM, SC_NEG, SC_OUT
  } scl_e;

endpackage

/* sv/amp_ram.sv */
// Generic simple dual-port RAM with registered read.
module amp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/amp_scale.sv */
// Shared multi-cycle unit: floor(probability * value / 2^16) on signed values.
module amp_scale import amp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic [PROB_W-1:0]        prob_i,
  input  logic signed [VAL_W-1:0]  val_i,
  output logic                     done_o,
  output logic signed [TERM_W-1:0] term_o
);

  scl_e state_q, state_d;

  logic [PROB_W-1:0]        prob_q;
  logic [VAL_W-1:0]         mag_q;
  logic                     neg_q;
  logic [40:0]              lo_q;
  logic [40:0]              hi_q;
  logic [48:0]              q_q;
  logic signed [TERM_W-1:0] term_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SC_IDLE: if (go_i) state_d = SC_LO;
      SC_LO:   state_d = SC_HI;
      SC_HI:   state_d = SC_SUM;
      SC_SUM:  state_d = SC_NEG;
      SC_NEG:  state_d = SC_OUT;
      SC_OUT:  state_d = SC_IDLE;
      default: state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SC_IDLE: begin
        if (go_i) begin
          prob_q <= prob_i;
          neg_q  <= val_i[VAL_W-1];
          mag_q  <= val_i[VAL_W-1] ? VAL_W'(-val_i) : VAL_W'(val_i);
        end
      end
      SC_LO: lo_q <= 41'(prob_q) * 41'(mag_q[23:0]);
      SC_HI: hi_q <= 41'(prob_q) * 41'(mag_q[47:24]);
      // Round the magnitude up for negative values so the result floors.
      SC_SUM: q_q <= {hi_q, 8'b0} + 49'(lo_q[40:16])
                     + 49'(neg_q && (lo_q[15:0] != 16'd0));
      SC_NEG: term_q <= neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
      default: ;
    endcase
  end

  assign done_o = (state_q == SC_OUT);
  assign term_o = term_q;

endmodule

/* sv/amp_seq.sv */
// Sequencer of the backward dynamic program, profile and policy memories.
module amp_seq import amp_pkg::*; #(
  parameter int CostBins = COST_BINS_DEF,
  parameter int TimeBins = TIME_BINS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_i,
  input  logic [1:0]        mode_i,
  input  logic [IDX_W-1:0]  cost_from_i,
  input  logic [IDX_W-1:0]  time_index_i,
  input  logic [IDX_W-1:0]  cost_to_i,
  input  logic [PROB_W-1:0] probability_i,
  input  cfg_t              cfg_i,
  output logic              busy_o,
  output res_t              res_o
);

  localparam int CW   = $clog2(CostBins);
  localparam int TW   = $clog2(TimeBins);
  localparam int PA   = $clog2(CostBins * TimeBins * CostBins);
  localparam int CA   = $clog2(CostBins * TimeBins);
  localparam int PD_W = VAL_W + IDX_W + 1;

  seq_e state_q, state_d;

  logic [CW-1:0]            ci_q, cj_q;
  logic [TW-1:0]            ti_q, tj_q;
  logic                     stop_ph_q, first_q, sbest_q, rd_ok_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [VAL_W-1:0]  best_q;
  logic [IDX_W-1:0]         dbest_q;
  logic [31:0]              kc_q, kt_q;
  logic signed [UTIL_W-1:0] u_q;

  logic [TW-1:0]            dt;
  logic                     cj_last, tj_last, ci_last, ti_zero;
  logic [CW-1:0]            u_c;
  logic [UTIL_W-2:0]        u_sum;
  logic signed [VAL_W-1:0]  sat_acc, u_ext;
  logic                     take;

  logic                     prof_we;
  logic [PA-1:0]            prof_waddr, prof_raddr;
  logic [PROB_W-1:0]        prof_rdata;
  logic                     pol_we;
  logic [CA-1:0]            pol_waddr, pol_raddr;
  logic [PD_W-1:0]          pol_wdata, pol_rdata;
  logic [TW-1:0]            wcol;

  logic                     scl_go, scl_done;
  logic signed [VAL_W-1:0]  scl_val;
  logic signed [TERM_W-1:0] scl_term;

  logic                     acc_in, load_ok, read_ok;

  assign acc_in  = req_i && (state_q == SQ_IDLE);
  assign load_ok = (32'(cost_from_i) < CostBins) && (32'(time_index_i) < TimeBins)
                   && (32'(cost_to_i) < CostBins);
  assign read_ok = (32'(cost_from_i) < CostBins) && (32'(time_index_i) < TimeBins);

  assign dt      = tj_q - ti_q;
  assign cj_last = (cj_q == ci_q);
  assign tj_last = (tj_q == TW'(TimeBins - 1));
  assign ci_last = (ci_q == CW'(CostBins - 1));
  assign ti_zero = (ti_q == '0);

  // Utility: -(cost * weight_cost + time * weight_time), both constants premultiplied.
  assign u_c   = (state_q == SQ_INIT_U) ? ci_q : cj_q;
  assign u_sum = (UTIL_W-1)'(u_c) * (UTIL_W-1)'(kc_q) + (UTIL_W-1)'(tj_q) * (UTIL_W-1)'(kt_q);
  assign u_ext = VAL_W'(u_q);

  // Saturate the accumulated sum to 48 bits.
  always_comb begin
    if (acc_q[ACC_W-1:VAL_W-1] == '0 || acc_q[ACC_W-1:VAL_W-1] == '1) begin
      sat_acc = acc_q[VAL_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      sat_acc = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  assign take = stop_ph_q ? (first_q || (sat_acc > best_q)) : (sat_acc > best_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (acc_in && mode_i == MODE_COMPUTE) state_d = SQ_PREP;
        else if (acc_in && mode_i == MODE_READ) state_d = SQ_READ;
      end
      SQ_READ:   state_d = SQ_IDLE;
      SQ_PREP:   state_d = SQ_INIT_U;
      SQ_INIT_U: state_d = SQ_INIT_W;
      SQ_INIT_W: state_d = ci_last ? SQ_UTIL : SQ_INIT_U;
      SQ_UTIL:   state_d = SQ_FETCH;
      SQ_FETCH:  state_d = SQ_SCALE;
      SQ_SCALE:  if (scl_done) state_d = cj_last ? SQ_DECIDE : SQ_UTIL;
      SQ_DECIDE: begin
        if ((stop_ph_q && dt != '0) || !tj_last) state_d = SQ_UTIL;
        else state_d = SQ_WRITE;
      end
      SQ_WRITE:  state_d = (!ci_last || !ti_zero) ? SQ_UTIL : SQ_DONE;
      SQ_DONE:   state_d = SQ_IDLE;
      default:   state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SQ_IDLE: rd_ok_q <= read_ok;
      SQ_PREP: begin
        kc_q <= 32'(cfg_i.cost_width) * 32'(cfg_i.weight_cost);
        kt_q <= 32'(cfg_i.time_width) * 32'(cfg_i.weight_time);
        ci_q <= '0;
        tj_q <= TW'(TimeBins - 1);
      end
      SQ_INIT_U: u_q <= -$signed({1'b0, u_sum});
      SQ_INIT_W: begin
        if (!ci_last) begin
          ci_q <= ci_q + 1'b1;
        end else begin
          ci_q      <= '0;
          ti_q      <= TW'(TimeBins - 2);
          tj_q      <= TW'(TimeBins - 2);
          cj_q      <= '0;
          acc_q     <= '0;
          stop_ph_q <= 1'b1;
          first_q   <= 1'b1;
        end
      end
      SQ_UTIL: u_q <= -$signed({1'b0, u_sum});
      SQ_SCALE: begin
        if (scl_done) begin
          acc_q <= acc_q + ACC_W'(scl_term);
          if (!cj_last) cj_q <= cj_q + 1'b1;
        end
      end
      SQ_DECIDE: begin
        if (take) begin
          best_q  <= sat_acc;
          sbest_q <= stop_ph_q;
          dbest_q <= IDX_W'(dt);
        end
        first_q <= 1'b0;
        acc_q   <= '0;
        cj_q    <= '0;
        if (stop_ph_q && dt != '0) begin
          stop_ph_q <= 1'b0;
        end else if (!tj_last) begin
          tj_q      <= tj_q + 1'b1;
          stop_ph_q <= 1'b1;
        end
      end
      SQ_WRITE: begin
        first_q   <= 1'b1;
        stop_ph_q <= 1'b1;
        if (!ci_last) begin
          ci_q <= ci_q + 1'b1;
          tj_q <= ti_q;
        end else if (!ti_zero) begin
          ci_q <= '0;
          ti_q <= ti_q - 1'b1;
          tj_q <= ti_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Memory ports.
  assign prof_we    = acc_in && (mode_i == MODE_LOAD) && load_ok;
  assign prof_waddr = PA'((32'(cost_from_i) * TimeBins + 32'(time_index_i)) * CostBins
                          + 32'(cost_to_i));
  assign prof_raddr = PA'((32'(ci_q) * TimeBins + 32'(dt)) * CostBins + 32'(cj_q));

  assign pol_we    = (state_q == SQ_INIT_W) || (state_q == SQ_WRITE);
  assign wcol      = (state_q == SQ_INIT_W) ? tj_q : ti_q;
  assign pol_waddr = CA'(32'(ci_q) * TimeBins + 32'(wcol));
  assign pol_wdata = (state_q == SQ_INIT_W) ? {u_ext, {IDX_W{1'b0}}, 1'b1}
                                            : {best_q, dbest_q, sbest_q};
  assign pol_raddr = (state_q == SQ_IDLE)
                     ? CA'(32'(cost_from_i) * TimeBins + 32'(time_index_i))
                     : CA'(32'(cj_q) * TimeBins + 32'(tj_q));

  amp_ram #(.Width(PROB_W), .Depth(CostBins * TimeBins * CostBins)) u_prof (
    .clk_i   (clk_i),
    .we_i    (prof_we),
    .waddr_i (prof_waddr),
    .wdata_i (probability_i),
    .raddr_i (prof_raddr),
    .rdata_o (prof_rdata)
  );

  amp_ram #(.Width(PD_W), .Depth(CostBins * TimeBins)) u_pol (
    .clk_i   (clk_i),
    .we_i    (pol_we),
    .waddr_i (pol_waddr),
    .wdata_i (pol_wdata),
    .raddr_i (pol_raddr),
    .rdata_o (pol_rdata)
  );

  assign scl_go  = (state_q == SQ_FETCH);
  assign scl_val = stop_ph_q ? u_ext : $signed(pol_rdata[PD_W-1:IDX_W+1]);

  amp_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (scl_go),
    .prob_i (prof_rdata),
    .val_i  (scl_val),
    .done_o (scl_done),
    .term_o (scl_term)
  );

  always_comb begin
    res_o              = '0;
    res_o.valid        = (state_q == SQ_READ) || (state_q == SQ_DONE);
    res_o.compute_done = (state_q == SQ_DONE);
    if (state_q == SQ_READ && rd_ok_q) begin
      res_o.policy_value = $signed(pol_rdata[PD_W-1:IDX_W+1]);
      res_o.wait_time    = WAIT_W'(pol_rdata[IDX_W:1]) * WAIT_W'(cfg_i.time_width);
      res_o.stop_flag    = pol_rdata[0];
    end
  end

  assign busy_o = (state_q != SQ_IDLE);

endmodule

/* sv/anytime_monitoring_policy_dp.sv */
// Top level: register port and policy builder.
// Load: busy stays low, so loads stream one per cycle.
// Read: result in the cycle after the request, busy high for that one cycle.
// Compute: busy through a prep step, a utility and a write step per last-column cell,
//   a utility, fetch and scale step per profile term, a decide per sum, a write per cell.
// Reset clears the sequencer and sets every register to 256; memories hold garbage.
module anytime_monitoring_policy_dp import amp_pkg::*; #(
  parameter int CostBins = COST_BINS_DEF,
  parameter int TimeBins = TIME_BINS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode_i,
  input  logic [IDX_W-1:0]        cost_from_i,
  input  logic [IDX_W-1:0]        time_index_i,
  input  logic [IDX_W-1:0]        cost_to_i,
  input  logic [PROB_W-1:0]       probability_i,
  output logic                    out_valid_o,
  output logic signed [VAL_W-1:0] policy_value_o,
  output logic [WAIT_W-1:0]       wait_time_o,
  output logic                    stop_flag_o,
  output logic                    compute_done_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t cfg_q;
  res_t res;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight_cost <= CFG_W'(256);
      cfg_q.weight_time <= CFG_W'(256);
      cfg_q.cost_width  <= CFG_W'(256);
      cfg_q.time_width  <= CFG_W'(256);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_WEIGHT_COST: cfg_q.weight_cost <= pwdata[CFG_W-1:0];
        REG_WEIGHT_TIME: cfg_q.weight_time <= pwdata[CFG_W-1:0];
        REG_COST_WIDTH:  cfg_q.cost_width  <= pwdata[CFG_W-1:0];
        REG_TIME_WIDTH:  cfg_q.time_width  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WEIGHT_COST: prdata = 32'(cfg_q.weight_cost);
      REG_WEIGHT_TIME: prdata = 32'(cfg_q.weight_time);
      REG_COST_WIDTH:  prdata = 32'(cfg_q.cost_width);
      REG_TIME_WIDTH:  prdata = 32'(cfg_q.time_width);
      default:         prdata = '0;
    endcase
  end

  amp_seq #(.CostBins(CostBins), .TimeBins(TimeBins)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (start),
    .mode_i        (mode_i),
    .cost_from_i   (cost_from_i),
    .time_index_i  (time_index_i),
    .cost_to_i     (cost_to_i),
    .probability_i (probability_i),
    .cfg_i         (cfg_q),
    .busy_o        (busy),
    .res_o         (res)
  );

  assign out_valid_o    = res.valid;
  assign policy_value_o = res.policy_value;
  assign wait_time_o    = res.wait_time;
  assign stop_flag_o    = res.stop_flag;
  assign compute_done_o = res.compute_done;

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && mode_i == MODE_COMPUTE |=> busy)
    else $error("compute request did not raise busy");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy)
    else $error("result shown while idle");

  a_fell_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(out_valid_o))
    else $error("busy dropped without a result");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    compute_done_o |-> out_valid_o && policy_value_o == '0 && !stop_flag_o)
    else $error("compute result carries data");

endmodule

/* tb/anytime_monitoring_policy_dp_tb.sv */
// Testbench for the monitoring-policy builder: random profile loads, policy sweeps and cell reads.
`timescale 1ns / 100ps

module anytime_monitoring_policy_dp_tb;
  import amp_pkg::*;

  localparam int NC = COST_BINS_DEF;
  localparam int NT = TIME_BINS_DEF;
  localparam int IDLE_LIMIT = 2000000;
  localparam longint VMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint VMIN = -VMAX - 1;

  typedef struct {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  cost_from;
    logic [IDX_W-1:0]  time_index;
    logic [IDX_W-1:0]  cost_to;
    logic [PROB_W-1:0] probability;
  } request_t;

  typedef struct {
    logic signed [VAL_W-1:0] policy_value;
    logic [WAIT_W-1:0]       wait_time;
    logic                    stop_flag;
    logic                    compute_done;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode_i = '0;
  logic [IDX_W-1:0] cost_from_i = '0, time_index_i = '0, cost_to_i = '0;
  logic [PROB_W-1:0] probability_i = '0;
  logic out_valid_o;
  logic signed [VAL_W-1:0] policy_value_o;
  logic [WAIT_W-1:0] wait_time_o;
  logic stop_flag_o, compute_done_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  anytime_monitoring_policy_dp uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // policy model state
  logic [CFG_W-1:0] m_wcost, m_wtime, m_cwidth, m_twidth;
  logic [PROB_W-1:0] prof_mem [NC*NT*NC];
  longint cell_value [NC*NT];
  int unsigned cell_wait [NC*NT];
  bit cell_stop [NC*NT];

  request_t pending_reqs[$];
  cell_result_t expected_cells[$];
  request_t cur_req;
  int gap_left = 0, burst_left = 0;
  int errors = 0;
  int idle_cycles = 0;

  function automatic longint utility(int cb, int tb);
    longint c, t;
    c = longint'(cb) * m_cwidth;
    t = longint'(tb) * m_twidth;
    return -(c * m_wcost + t * m_wtime);
  endfunction

  // floor(p * v / 2^16)
  function automatic logic signed [95:0] scaled(logic [PROB_W-1:0] p, longint v);
    logic signed [95:0] a, b;
    a = v;
    b = {79'd0, p};
    return (a * b) >>> 16;
  endfunction

  function automatic longint sat48(logic signed [95:0] x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return longint'(x);
  endfunction

  function automatic void sweep_policy();
    longint best, acc;
    logic signed [95:0] sum;
    bit have, sbest;
    int dbest, dt, base;
    for (int ci = 0; ci < NC; ci++) begin
      cell_value[ci*NT + NT-1] = sat48(utility(ci, NT-1));
      cell_wait[ci*NT + NT-1] = 0;
      cell_stop[ci*NT + NT-1] = 1'b1;
    end
    for (int ti = NT-2; ti >= 0; ti--) begin
      for (int ci = 0; ci < NC; ci++) begin
        have = 0; sbest = 1; best = 0; dbest = 0;
        for (int tj = ti; tj < NT; tj++) begin
          dt = tj - ti;
          base = (ci*NT + dt) * NC;
          sum = 0;
          for (int cj = 0; cj <= ci; cj++) sum += scaled(prof_mem[base+cj], utility(cj, tj));
          acc = sat48(sum);
          if (!have || acc > best) begin
            have = 1; best = acc; sbest = 1; dbest = dt;
          end
          if (dt != 0) begin
            sum = 0;
            for (int cj = 0; cj <= ci; cj++)
              sum += scaled(prof_mem[base+cj], cell_value[cj*NT + tj]);
            acc = sat48(sum);
            if (acc > best) begin
              best = acc; sbest = 0; dbest = dt;
            end
          end
        end
        cell_value[ci*NT + ti] = best;
        cell_wait[ci*NT + ti] = dbest;
        cell_stop[ci*NT + ti] = sbest;
      end
    end
  endfunction

  function automatic void predict(request_t r);
    cell_result_t e;
    int a;
    e = '{default: '0};
    case (r.mode)
      MODE_LOAD: begin
        if (r.cost_from < NC && r.time_index < NT && r.cost_to < NC)
          prof_mem[(r.cost_from*NT + r.time_index)*NC + r.cost_to] = r.probability;
      end
      MODE_COMPUTE: begin
        sweep_policy();
        e.compute_done = 1'b1;
        expected_cells.push_back(e);
      end
      MODE_READ: begin
        if (r.cost_from < NC && r.time_index < NT) begin
          a = r.cost_from*NT + r.time_index;
          e.policy_value = cell_value[a][VAL_W-1:0];
          e.wait_time = WAIT_W'(cell_wait[a] * m_twidth);
          e.stop_flag = cell_stop[a];
        end
        expected_cells.push_back(e);
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // driver: hold start until the request is taken, bursts with random gaps
  always @(posedge clk_i) begin : driver
    logic take;
    take = start && !busy;
    if (rst_ni) begin
      if (take) begin
        predict(cur_req);
        idle_cycles = 0;
      end
      if (take || !start) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          mode_i <= cur_req.mode;
          cost_from_i <= cur_req.cost_from;
          time_index_i <= cur_req.time_index;
          cost_to_i <= cur_req.cost_to;
          probability_i <= cur_req.probability;
          start <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20);
            gap_left = $urandom_range(0, 7);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    cell_result_t e;
    if (rst_ni && out_valid_o) begin
      idle_cycles = 0;
      if (expected_cells.size() == 0) begin
        report("unexpected result value", 64'(policy_value_o), 64'd0);
      end else begin
        e = expected_cells.pop_front();
        if (policy_value_o !== e.policy_value)
          report("policy_value", 64'(policy_value_o), 64'(e.policy_value));
        if (wait_time_o !== e.wait_time)
          report("wait_time", 64'(wait_time_o), 64'(e.wait_time));
        if (stop_flag_o !== e.stop_flag)
          report("stop_flag", 64'(stop_flag_o), 64'(e.stop_flag));
        if (compute_done_o !== e.compute_done)
          report("compute_done", 64'(compute_done_o), 64'(e.compute_done));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_req(logic [1:0] m, int cf, int ti, int ct, int p);
    request_t r;
    r.mode = m;
    r.cost_from = IDX_W'(cf);
    r.time_index = IDX_W'(ti);
    r.cost_to = IDX_W'(ct);
    r.probability = PROB_W'(p);
    pending_reqs.push_back(r);
  endtask

  function automatic int rand_prob(int cf);
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(0, 131071);
      default: return $urandom_range(0, 65536 / (cf + 1));
    endcase
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || start || expected_cells.size() != 0);
    // a trailing load gives no result; let it settle
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom_range(0, 65535)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WEIGHT_COST: m_wcost = val;
      REG_WEIGHT_TIME: m_wtime = val;
      REG_COST_WIDTH:  m_cwidth = val;
      default:         m_twidth = val;
    endcase
  endtask

  task automatic write_all(int wc, int wt, int cw, int tw);
    write_reg(REG_WEIGHT_COST, CFG_W'(wc));
    write_reg(REG_WEIGHT_TIME, CFG_W'(wt));
    write_reg(REG_COST_WIDTH, CFG_W'(cw));
    write_reg(REG_TIME_WIDTH, CFG_W'(tw));
  endtask

  task automatic add_reads(int n);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 9) == 0)
        add_req(MODE_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 131071));
      else
        add_req(MODE_READ, $urandom_range(0, NC-1), $urandom_range(0, NT-1),
                $urandom_range(0, 63), $urandom_range(0, 131071));
  endtask

  initial begin
    m_wcost = 256; m_wtime = 256; m_cwidth = 256; m_twidth = 256;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill every profile entry a sweep touches
    for (int cf = 0; cf < NC; cf++)
      for (int ti = 0; ti < NT; ti++)
        for (int ct = 0; ct <= cf; ct++)
          add_req(MODE_LOAD, cf, ti, ct, rand_prob(cf));
    add_req(MODE_LOAD, 63, 63, 63, 131071);
    add_req(MODE_LOAD, 0, 0, NC, 131071);
    add_req(MODE_LOAD, NC, 0, 0, 131071);
    add_req(MODE_LOAD, 0, NT, 0, 131071);
    add_req(MODE_LOAD, NC-1, NT-1, 0, 65536);
    add_req(MODE_LOAD, NC-1, 0, NC-1, 131071);
    add_req(MODE_NONE, 5, 5, 5, 100);
    add_req(MODE_COMPUTE, 0, 0, 0, 0);
    add_req(MODE_READ, 0, 0, 0, 0);
    add_req(MODE_READ, NC-1, NT-1, 0, 0);
    add_req(MODE_READ, NC-1, 0, 0, 0);
    add_req(MODE_READ, 0, NT-1, 0, 0);
    add_req(MODE_READ, 63, 0, 0, 0);
    add_req(MODE_READ, 0, 63, 0, 0);
    add_req(MODE_READ, NC, NT, 63, 131071);
    add_req(MODE_NONE, 63, 63, 63, 131071);
    add_reads(20);
    wait_drained();

    // largest weights and widths with probabilities of one or above: saturation
    write_all(65535, 65535, 65535, 65535);
    for (int i = 0; i < 40; i++)
      add_req(MODE_LOAD, NC-1 - $urandom_range(0, 3), $urandom_range(0, NT-1),
              $urandom_range(0, NC-1), $urandom_range(65536, 131071));
    add_req(MODE_COMPUTE, 0, 0, 0, 0);
    add_reads(30);
    wait_drained();

    write_all(0, 0, 0, 0);
    add_req(MODE_COMPUTE, 0, 0, 0, 0);
    add_reads(20);
    wait_drained();

    write_all($urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    for (int i = 0; i < 700; i++) begin
      if (i == 650) begin
        add_req(MODE_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 63), $urandom_range(0, 131071));
      end else if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 19) == 0)
          add_req(MODE_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom_range(0, 131071));
        else begin
          int cf;
          cf = $urandom_range(0, NC-1);
          add_req(MODE_LOAD, cf, $urandom_range(0, NT-1), $urandom_range(0, NC-1),
                  rand_prob(cf));
        end
      end else if ($urandom_range(0, 29) == 0) begin
        add_req(MODE_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 131071));
      end else begin
        add_reads(1);
      end
    end
    wait_drained();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
